// ----- hdl/rpsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpsa_pkg
// Shared types and codes for the reference counted palette slot allocator.
// ----------------------------------------------------------------------------
package rpsa_pkg;

  localparam int BANK_COLORS = 16;
  localparam int STAGE_DEPTH = BANK_COLORS - 1;
  localparam int COLOR_W     = 16;
  localparam int COUNT_W     = 16;
  localparam int CK_W        = 7;
  localparam int BRC_W       = 8;
  localparam int SUM_W       = 20;
  localparam int OUT_IDX_W   = 8;
  localparam int POS_W       = 4;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_RSV_COLOR = 3'd0;
  localparam logic [OP_W-1:0] OP_REL_COLOR = 3'd1;
  localparam logic [OP_W-1:0] OP_STAGE     = 3'd2;
  localparam logic [OP_W-1:0] OP_RSV_BANK  = 3'd3;
  localparam logic [OP_W-1:0] OP_REL_BANK  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_NEW    = 3'd0;
  localparam logic [STATUS_W-1:0] STS_SHARED = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] STS_DECR   = 3'd4;
  localparam logic [STATUS_W-1:0] STS_FREED  = 3'd5;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [BRC_W-1:0]   BCOUNT_MAX = 8'hFF;
  localparam logic [POS_W-1:0]   LAST_POS   = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_EMIT,
    ST_BANK_WR
  } state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
    logic               used;
  } slot_entry_t;

endpackage

// ----- hdl/refcounted_palette_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// refcounted_palette_slot_allocator
// Palette slot allocator with per-colour and per-bank reference counts.
// ----------------------------------------------------------------------------
// Sequence: a colour op scans all NUM_SLOTS slot entries, resolves, and then
// emits one result; a bank op scans the (NUM_SLOTS/16)*16 bank slots, and an
// allocate or free then sends 15 results, one per cycle while out_stall is low.
// A stage op returns nothing.
// Throughput: one transaction at a time; the next op is taken the cycle after
// the last result is loaded, set by the linear scan through the slot memory
// (one entry read per cycle).
// Reset: synchronous; clears all valid bits, counts, bank tables and staging.
module refcounted_palette_slot_allocator #(
  parameter int NUM_SLOTS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rpsa_pkg::OP_W-1:0]      op,
  input  logic [rpsa_pkg::COLOR_W-1:0]   color,
  input  logic [rpsa_pkg::POS_W-1:0]     position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rpsa_pkg::STATUS_W-1:0]  status,
  output logic [rpsa_pkg::OUT_IDX_W-1:0] index,
  output logic                           write_valid,
  output logic [rpsa_pkg::OUT_IDX_W-1:0] write_slot,
  output logic [rpsa_pkg::COLOR_W-1:0]   write_data,
  output logic                           last
);
  import rpsa_pkg::*;

  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int NUM_BANKS  = NUM_SLOTS / BANK_COLORS;
  localparam int BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int BANK_SLOTS = NUM_BANKS * BANK_COLORS;
  localparam logic [SLOT_W:0] COLOR_LIMIT = (SLOT_W+1)'(NUM_SLOTS);
  localparam logic [SLOT_W:0] BANK_LIMIT  = (SLOT_W+1)'(BANK_SLOTS);

  // slot memory and per-entry valid bits
  slot_entry_t             slot_mem [NUM_SLOTS];
  slot_entry_t             rdata;
  logic [NUM_SLOTS-1:0]    entry_valid;

  // staging and bank tables
  logic [COLOR_W-1:0]      staged [STAGE_DEPTH];
  logic [SUM_W-1:0]        staged_sum;
  logic [CK_W-1:0]         bank_ck [NUM_BANKS];
  logic [BRC_W-1:0]        bank_rc [NUM_BANKS];

  // control
  state_t                  state, state_next;
  logic [OP_W-1:0]         cur_op;
  logic [COLOR_W-1:0]      cur_color;
  logic [SLOT_W:0]         cnt;
  logic                    chk_v;
  logic                    chk_entry_valid;
  logic [SLOT_W-1:0]       chk_slot;

  // scan results
  logic                    hit, free_hit;
  logic [SLOT_W-1:0]       hit_slot, free_slot;
  logic [COUNT_W-1:0]      hit_count;
  logic                    same_acc, free_acc;
  logic                    bank_hit, free_bank_hit;
  logic [BANK_W-1:0]       hit_bank, free_bank;

  // resolved result
  logic [STATUS_W-1:0]     res_status;
  logic [OUT_IDX_W-1:0]    res_index;
  logic                    res_wv;
  logic [OUT_IDX_W-1:0]    res_wslot;
  logic [COLOR_W-1:0]      res_wdata;
  logic                    res_mem_we;
  logic [SLOT_W-1:0]       res_slot;
  slot_entry_t             res_entry;
  logic [BANK_W-1:0]       wr_bank;
  logic                    wr_clear;
  logic [POS_W-1:0]        wr_j;

  // combinational helpers
  logic                    accept, out_free, is_bank, issue;
  logic [SLOT_W:0]         limit;
  logic [SLOT_W-1:0]       raddr;
  slot_entry_t             e;
  logic [POS_W-1:0]        e_j;
  logic [BANK_W-1:0]       e_b;
  logic                    same_n, free_n;
  logic [CK_W-1:0]         ck_raw, ck;
  logic [BRC_W-1:0]        bank_dec;
  logic                    bank_write_go;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_waddr;
  slot_entry_t             mem_wdata;
  logic [SLOT_W-1:0]       bank_waddr;
  logic [COUNT_W-1:0]      count_dec;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign is_bank  = (cur_op == OP_RSV_BANK) || (cur_op == OP_REL_BANK);
  assign limit    = is_bank ? BANK_LIMIT : COLOR_LIMIT;
  assign issue    = (state == ST_SCAN) && (cnt < limit);
  assign raddr    = issue ? cnt[SLOT_W-1:0] : '0;

  // checksum of staged colors, zero maps to one
  assign ck_raw = staged_sum[12:6];
  assign ck     = (ck_raw == '0) ? CK_W'(1) : ck_raw;

  // entry under check, with reset value where never written
  always_comb begin
    if (chk_entry_valid) begin
      e = rdata;
    end else begin
      e.color = '0;
      e.count = '0;
      e.used  = (chk_slot == '0);
    end
    e_j    = chk_slot[POS_W-1:0];
    e_b    = BANK_W'(chk_slot >> POS_W);
    same_n = same_acc && (e.color == staged[e_j - POS_W'(1)]);
    free_n = free_acc && !e.used;
  end

  assign bank_dec      = (bank_rc[hit_bank] != '0) ? bank_rc[hit_bank] - BRC_W'(1) : '0;
  assign bank_write_go = ((cur_op == OP_RSV_BANK) && !bank_hit && free_bank_hit) ||
                         ((cur_op == OP_REL_BANK) && bank_hit && (bank_dec == '0));
  assign count_dec     = hit_count - COUNT_W'(1);
  assign bank_waddr    = SLOT_W'({wr_bank, wr_j});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_RSV_COLOR || op == OP_REL_COLOR ||
                       op == OP_RSV_BANK || op == OP_REL_BANK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !chk_v) state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        state_next = bank_write_go ? ST_BANK_WR : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_BANK_WR: begin
        if (out_free && wr_j == LAST_POS) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: stall and memory write port
  always_comb begin
    in_stall  = (state != ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = res_slot;
    mem_wdata = res_entry;
    unique case (state)
      ST_EMIT: begin
        mem_we = out_free && res_mem_we;
      end
      ST_BANK_WR: begin
        mem_we          = out_free;
        mem_waddr       = bank_waddr;
        mem_wdata.color = wr_clear ? '0 : staged[wr_j - POS_W'(1)];
        mem_wdata.count = '0;
        mem_wdata.used  = !wr_clear;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    rdata <= slot_mem[raddr];
  end

  // state and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_valid <= '0;
    end else begin
      state <= state_next;
      if (mem_we) entry_valid[mem_waddr] <= 1'b1;
    end
  end

  // staging registers and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGE_DEPTH; i++) staged[i] <= '0;
      staged_sum <= '0;
    end else if (accept && op == OP_STAGE && position != '0) begin
      staged[position - POS_W'(1)] <= color;
      staged_sum <= staged_sum - SUM_W'(staged[position - POS_W'(1)]) + SUM_W'(color);
    end
  end

  // scan pipeline and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_v <= 1'b0;
      cnt   <= '0;
    end else if (state == ST_IDLE) begin
      chk_v <= 1'b0;
      if (accept) begin
        cur_op        <= op;
        cur_color     <= color;
        cnt           <= '0;
        hit           <= 1'b0;
        free_hit      <= 1'b0;
        bank_hit      <= 1'b0;
        free_bank_hit <= 1'b0;
        same_acc      <= 1'b1;
        free_acc      <= 1'b1;
      end
    end else if (state == ST_SCAN) begin
      if (issue) cnt <= cnt + (SLOT_W+1)'(1);
      chk_v           <= issue;
      chk_slot        <= raddr;
      chk_entry_valid <= entry_valid[raddr];
      if (chk_v) begin
        if (is_bank) begin
          // bank slot zero is neither compared nor required free
          if (e_j != '0) begin
            if (e_j == LAST_POS) begin
              if (!bank_hit && same_n && bank_ck[e_b] == ck) begin
                bank_hit <= 1'b1;
                hit_bank <= e_b;
              end
              if (!free_bank_hit && free_n) begin
                free_bank_hit <= 1'b1;
                free_bank     <= e_b;
              end
              same_acc <= 1'b1;
              free_acc <= 1'b1;
            end else begin
              same_acc <= same_n;
              free_acc <= free_n;
            end
          end
        end else begin
          if (!hit && e.count != '0 && e.color == cur_color) begin
            hit       <= 1'b1;
            hit_slot  <= chk_slot;
            hit_count <= e.count;
          end
          if (!free_hit && !e.used) begin
            free_hit  <= 1'b1;
            free_slot <= chk_slot;
          end
        end
      end
    end else begin
      chk_v <= 1'b0;
    end
  end

  // resolve the scan into a result and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        bank_ck[i] <= '0;
        bank_rc[i] <= '0;
      end
    end else if (state == ST_RESOLVE) begin
      res_status <= STS_ABSENT;
      res_index  <= '0;
      res_wv     <= 1'b0;
      res_wslot  <= '0;
      res_wdata  <= '0;
      res_mem_we <= 1'b0;
      res_slot   <= hit_slot;
      res_entry  <= '{color: cur_color, count: hit_count, used: 1'b1};
      wr_j       <= POS_W'(1);
      wr_clear   <= 1'b0;
      wr_bank    <= free_bank;
      priority case (cur_op)
        OP_RSV_COLOR: begin
          if (hit) begin
            res_status <= STS_SHARED;
            res_index  <= OUT_IDX_W'(hit_slot);
            res_mem_we <= 1'b1;
            res_entry  <= '{color: cur_color,
                            count: (hit_count == COUNT_MAX) ? hit_count
                                   : hit_count + COUNT_W'(1),
                            used: 1'b1};
          end else if (free_hit) begin
            res_status <= STS_NEW;
            res_index  <= OUT_IDX_W'(free_slot);
            res_wv     <= 1'b1;
            res_wslot  <= OUT_IDX_W'(free_slot);
            res_wdata  <= cur_color;
            res_mem_we <= 1'b1;
            res_slot   <= free_slot;
            res_entry  <= '{color: cur_color, count: COUNT_W'(1), used: 1'b1};
          end else begin
            res_status <= STS_FULL;
          end
        end
        OP_REL_COLOR: begin
          if (hit) begin
            res_index  <= OUT_IDX_W'(hit_slot);
            res_mem_we <= 1'b1;
            if (count_dec == '0) begin
              res_status <= STS_FREED;
              res_wv     <= 1'b1;
              res_wslot  <= OUT_IDX_W'(hit_slot);
              res_entry  <= '{color: '0, count: '0, used: 1'b0};
            end else begin
              res_status <= STS_DECR;
              res_entry  <= '{color: cur_color, count: count_dec, used: 1'b1};
            end
          end
        end
        OP_RSV_BANK: begin
          if (bank_hit) begin
            res_status <= STS_SHARED;
            res_index  <= OUT_IDX_W'(hit_bank);
            if (bank_rc[hit_bank] != BCOUNT_MAX) begin
              bank_rc[hit_bank] <= bank_rc[hit_bank] + BRC_W'(1);
            end
          end else if (free_bank_hit) begin
            res_status         <= STS_NEW;
            res_index          <= OUT_IDX_W'(free_bank);
            bank_ck[free_bank] <= ck;
            bank_rc[free_bank] <= BRC_W'(1);
          end else begin
            res_status <= STS_FULL;
          end
        end
        OP_REL_BANK: begin
          if (bank_hit) begin
            res_index         <= OUT_IDX_W'(hit_bank);
            bank_rc[hit_bank] <= bank_dec;
            wr_bank           <= hit_bank;
            if (bank_dec == '0) begin
              res_status        <= STS_FREED;
              bank_ck[hit_bank] <= '0;
              wr_clear          <= 1'b1;
            end else begin
              res_status <= STS_DECR;
            end
          end
        end
        default: begin
          res_status <= STS_ABSENT;
        end
      endcase
    end else if (state == ST_BANK_WR && out_free) begin
      wr_j <= wr_j + POS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid   <= 1'b1;
      status      <= res_status;
      index       <= res_index;
      write_valid <= res_wv;
      write_slot  <= res_wslot;
      write_data  <= res_wdata;
      last        <= 1'b1;
    end else if (state == ST_BANK_WR && out_free) begin
      out_valid   <= 1'b1;
      status      <= res_status;
      index       <= res_index;
      write_valid <= 1'b1;
      write_slot  <= OUT_IDX_W'(bank_waddr);
      write_data  <= mem_wdata.color;
      last        <= (wr_j == LAST_POS);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hdl/rpsa_checker.sv -----
// ----------------------------------------------------------------------------
// rpsa_checker
// Port-level checks for the palette slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rpsa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic [rpsa_pkg::STATUS_W-1:0]  status,
  input logic [rpsa_pkg::OUT_IDX_W-1:0] index,
  input logic                           write_valid,
  input logic [rpsa_pkg::OUT_IDX_W-1:0] write_slot,
  input logic [rpsa_pkg::COLOR_W-1:0]   write_data,
  input logic                           last
);
  import rpsa_pkg::*;

  // hold off new transactions while a bank write burst is in flight
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken during a bank write burst");

  // non-final items only come from bank writes
  a_burst_writes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> write_valid)
    else $error("non-final result without a write");

  // an item without a write carries zero slot and data
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> write_slot == '0 && write_data == '0)
    else $error("write fields set without a write");

  // full and absent results are single items with index zero
  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STS_FULL || status == STS_ABSENT)
      |-> index == '0 && !write_valid && last)
    else $error("malformed full or absent result");

endmodule

bind refcounted_palette_slot_allocator rpsa_checker u_rpsa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .status      (status),
  .index       (index),
  .write_valid (write_valid),
  .write_slot  (write_slot),
  .write_data  (write_data),
  .last        (last)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the palette slot allocator. A scoreboard class
// predicts every result transaction from the accepted input transactions and
// compares each output field in order. The input is driven with directed
// corner cases, a palette fill, a bank count run-up and random sequences of
// colour and bank operations under several idle and stall settings.
// ----------------------------------------------------------------------------
module testbench;
  import rpsa_pkg::*;

  localparam int SLOTS     = 256;
  localparam int BANKS     = SLOTS / BANK_COLORS;
  localparam int QUIET_MAX = 20000;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] index;
    logic                 write_valid;
    logic [OUT_IDX_W-1:0] write_slot;
    logic [COLOR_W-1:0]   write_data;
    logic                 last;
  } palette_result_t;

  // Predicts allocator results and holds the ones not yet seen
  class palette_scoreboard;
    logic [COLOR_W-1:0] pal [SLOTS];
    logic               used [SLOTS];
    logic [COUNT_W-1:0] cnt [SLOTS];
    logic [CK_W-1:0]    bck [BANKS];
    logic [BRC_W-1:0]   bcnt [BANKS];
    logic [COLOR_W-1:0] staged [STAGE_DEPTH];
    palette_result_t    awaited [$];
    int                 errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        pal[i] = '0;
        used[i] = (i == 0);
        cnt[i] = '0;
      end
      for (int b = 0; b < BANKS; b++) begin
        bck[b] = '0;
        bcnt[b] = '0;
      end
      foreach (staged[i]) staged[i] = '0;
      errors = 0;
    endfunction

    function void push(logic [2:0] st, int idx, logic wv, int ws, logic [15:0] wd,
                       logic lst);
      palette_result_t r;
      r.status = st;
      r.index = idx[7:0];
      r.write_valid = wv;
      r.write_slot = ws[7:0];
      r.write_data = wd;
      r.last = lst;
      awaited.push_back(r);
    endfunction

    function logic [CK_W-1:0] stage_sum();
      logic [SUM_W-1:0] sum;
      logic [CK_W-1:0]  ck;
      sum = '0;
      foreach (staged[i]) sum += staged[i];
      ck = sum[12:6];
      return (ck == 0) ? 7'd1 : ck;
    endfunction

    function int find_slot(logic [15:0] c);
      for (int i = 0; i < SLOTS; i++)
        if (cnt[i] != 0 && pal[i] == c) return i;
      return -1;
    endfunction

    function int find_bank(logic [CK_W-1:0] ck);
      bit same;
      for (int b = 0; b < BANKS; b++) begin
        if (bck[b] != ck) continue;
        same = 1;
        for (int j = 1; j < BANK_COLORS; j++)
          if (pal[b*BANK_COLORS+j] != staged[j-1]) same = 0;
        if (same) return b;
      end
      return -1;
    endfunction

    // Write or clear slots 1..15 of a bank, one result per slot
    function void fill_bank(int b, logic [2:0] st, bit clr);
      int s;
      for (int j = 1; j < BANK_COLORS; j++) begin
        s = b * BANK_COLORS + j;
        pal[s] = clr ? 16'h0 : staged[j-1];
        used[s] = !clr;
        push(st, b, 1'b1, s, pal[s], j == BANK_COLORS - 1);
      end
    endfunction

    // Advance the model by one accepted input transaction
    function void note_input(logic [2:0] o, logic [15:0] c, logic [3:0] p);
      int s, b;
      logic [CK_W-1:0] ck;
      bit freeb;
      case (o)
        OP_RSV_COLOR: begin
          s = find_slot(c);
          if (s >= 0) begin
            if (cnt[s] != COUNT_MAX) cnt[s]++;
            push(STS_SHARED, s, 0, 0, 0, 1);
          end else begin
            s = -1;
            for (int i = 0; i < SLOTS && s < 0; i++) if (!used[i]) s = i;
            if (s < 0) push(STS_FULL, 0, 0, 0, 0, 1);
            else begin
              used[s] = 1;
              cnt[s] = 1;
              pal[s] = c;
              push(STS_NEW, s, 1, s, c, 1);
            end
          end
        end
        OP_REL_COLOR: begin
          s = find_slot(c);
          if (s < 0) push(STS_ABSENT, 0, 0, 0, 0, 1);
          else begin
            cnt[s]--;
            if (cnt[s] == 0) begin
              used[s] = 0;
              pal[s] = '0;
              push(STS_FREED, s, 1, s, 0, 1);
            end else push(STS_DECR, s, 0, 0, 0, 1);
          end
        end
        OP_STAGE: if (p != 0) staged[p-1] = c;
        OP_RSV_BANK: begin
          ck = stage_sum();
          b = find_bank(ck);
          if (b >= 0) begin
            if (bcnt[b] != BCOUNT_MAX) bcnt[b]++;
            push(STS_SHARED, b, 0, 0, 0, 1);
          end else begin
            b = -1;
            for (int k = 0; k < BANKS && b < 0; k++) begin
              freeb = 1;
              for (int j = 1; j < BANK_COLORS; j++)
                if (used[k*BANK_COLORS+j]) freeb = 0;
              if (freeb) b = k;
            end
            if (b < 0) push(STS_FULL, 0, 0, 0, 0, 1);
            else begin
              bck[b] = ck;
              bcnt[b] = 1;
              fill_bank(b, STS_NEW, 0);
            end
          end
        end
        OP_REL_BANK: begin
          b = find_bank(stage_sum());
          if (b < 0) push(STS_ABSENT, 0, 0, 0, 0, 1);
          else begin
            if (bcnt[b] != 0) bcnt[b]--;
            if (bcnt[b] != 0) push(STS_DECR, b, 0, 0, 0, 1);
            else begin
              bck[b] = '0;
              fill_bank(b, STS_FREED, 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(palette_result_t act);
      palette_result_t exp_r;
      if (awaited.size() == 0) begin
        $error("unexpected result transaction: status %0d index %0d",
               act.status, act.index);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (act.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, act.status);
        errors++;
      end
      if (act.index !== exp_r.index) begin
        $error("index: expected %0d, got %0d", exp_r.index, act.index);
        errors++;
      end
      if (act.write_valid !== exp_r.write_valid) begin
        $error("write_valid: expected %0d, got %0d", exp_r.write_valid,
               act.write_valid);
        errors++;
      end
      if (act.write_slot !== exp_r.write_slot) begin
        $error("write_slot: expected %0d, got %0d", exp_r.write_slot,
               act.write_slot);
        errors++;
      end
      if (act.write_data !== exp_r.write_data) begin
        $error("write_data: expected %h, got %h", exp_r.write_data,
               act.write_data);
        errors++;
      end
      if (act.last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, act.last);
        errors++;
      end
    endfunction

    // Pick a live colour, or any colour when 64 random slot picks find none
    function logic [15:0] live_color();
      int s;
      for (int tries = 0; tries < 64; tries++) begin
        s = $urandom_range(SLOTS - 1);
        if (cnt[s] != 0) return pal[s];
      end
      return 16'($urandom);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      op;
  logic [COLOR_W-1:0]   color;
  logic [POS_W-1:0]     position;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  status;
  logic [OUT_IDX_W-1:0] index;
  logic                 write_valid;
  logic [OUT_IDX_W-1:0] write_slot;
  logic [COLOR_W-1:0]   write_data;
  logic                 last;

  palette_scoreboard sb;
  int                idle_pct;
  int                stall_pct;
  int                holdoff;
  int                quiet;
  logic [COLOR_W-1:0] pattern [4][STAGE_DEPTH];
  logic [COLOR_W-1:0] pool [32];

  refcounted_palette_slot_allocator #(.NUM_SLOTS(SLOTS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .color(color), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .index(index), .write_valid(write_valid),
    .write_slot(write_slot), .write_data(write_data), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one input transaction and hold it until accepted
  task automatic send_item(logic [2:0] o, logic [15:0] c, logic [3:0] p);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = o;
    color = c;
    position = p;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(o, c, p);
  endtask

  task automatic stage_pattern(int k, bit noisy);
    for (int i = 0; i < STAGE_DEPTH; i++) begin
      send_item(OP_STAGE, pattern[k][i], 4'(i + 1));
      if (noisy && $urandom_range(9) == 0) send_item(OP_STAGE, 16'($urandom), 4'd0);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Random mix of colour and bank traffic
  task automatic random_items(int count);
    int r, k, p;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_item(OP_RSV_COLOR, ($urandom_range(1) ? pool[$urandom_range(31)]
                                                    : 16'($urandom)), 4'($urandom));
      end else if (r < 55) begin
        send_item(OP_REL_COLOR, ($urandom_range(4) ? sb.live_color() : 16'($urandom)),
                  4'($urandom));
      end else if (r < 62) begin
        send_item(3'($urandom_range(7, 5)), 16'($urandom), 4'($urandom));
      end else begin
        k = $urandom_range(3);
        // restage a whole pattern now and then, else touch one position
        if ($urandom_range(3) == 0) stage_pattern(k, 1);
        else begin
          p = $urandom_range(STAGE_DEPTH - 1);
          send_item(OP_STAGE, pattern[k][p], 4'(p + 1));
        end
        // corrupt one position now and then so no bank matches
        if ($urandom_range(5) == 0)
          send_item(OP_STAGE, 16'($urandom), 4'($urandom_range(15, 1)));
        send_item($urandom_range(1) ? OP_RSV_BANK : OP_REL_BANK, 16'($urandom),
                  4'($urandom));
      end
    end
  endtask

  // Stall the result side at random, or for a counted hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff > 0) begin
        out_stall = 1'b1;
        holdoff--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check results and watch for a hang
  initial begin
    palette_result_t act;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        act.status = status;
        act.index = index;
        act.write_valid = write_valid;
        act.write_slot = write_slot;
        act.write_data = write_data;
        act.last = last;
        sb.check_result(act);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else if (!rst) quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pct_in [4];
    int pct_out [4];
    logic [COLOR_W-1:0] tmp;
    pct_in = '{0, 80, 0, 29};
    pct_out = '{0, 0, 80, 29};
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_RSV_COLOR;
    color = '0;
    position = '0;
    idle_pct = 0;
    stall_pct = 0;
    holdoff = 0;
    foreach (pool[i]) pool[i] = 16'($urandom);
    foreach (pattern[k, i]) pattern[k][i] = 16'($urandom);
    // same colours in another order: equal checksum, different bank
    pattern[3] = pattern[0];
    tmp = pattern[3][0];
    pattern[3][0] = pattern[3][14];
    pattern[3][14] = tmp;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, sharing, release paths, ignored ops, zero bank
    send_item(OP_RSV_COLOR, 16'h0000, 4'd0);
    send_item(OP_RSV_COLOR, 16'hFFFF, 4'd15);
    send_item(OP_RSV_COLOR, 16'hFFFF, 4'd0);
    send_item(OP_REL_COLOR, 16'hFFFF, 4'd0);
    send_item(OP_REL_COLOR, 16'hFFFF, 4'd0);
    send_item(OP_REL_COLOR, 16'h1234, 4'd0);
    send_item(3'd5, 16'hFFFF, 4'd15);
    send_item(3'd6, 16'h0000, 4'd0);
    send_item(3'd7, 16'hAAAA, 4'd5);
    send_item(OP_STAGE, 16'hFFFF, 4'd0);
    send_item(OP_RSV_BANK, 16'h0, 4'd0);
    send_item(OP_RSV_BANK, 16'h0, 4'd0);
    send_item(OP_REL_BANK, 16'h0, 4'd0);
    send_item(OP_REL_BANK, 16'h0, 4'd0);
    send_item(OP_REL_BANK, 16'h0, 4'd0);
    send_item(OP_STAGE, 16'hFFFF, 4'd15);
    send_item(OP_RSV_BANK, 16'h0, 4'd0);
    send_item(OP_REL_BANK, 16'h0, 4'd0);

    // Hold the result side off while input keeps coming
    holdoff = 1500;
    for (int i = 0; i < 8; i++) send_item(OP_RSV_COLOR, pool[i], 4'd0);
    drain();

    // Bank count saturation, then one release from the top
    stage_pattern(1, 0);
    for (int i = 0; i < 256; i++) send_item(OP_RSV_BANK, 16'($urandom), 4'($urandom));
    send_item(OP_REL_BANK, 16'h0, 4'd0);
    drain();

    // Fill the palette with banks, then colours, until both report full
    for (int i = 0; i < 17; i++) begin
      send_item(OP_STAGE, 16'h4000 + 16'(i), 4'd1);
      send_item(OP_RSV_BANK, 16'h0, 4'd0);
    end
    for (int i = 0; i < 24; i++) send_item(OP_RSV_COLOR, 16'h8000 + 16'(i), 4'd0);
    for (int i = 0; i < 12; i++) send_item(OP_REL_COLOR, 16'h8000 + 16'(2 * i), 4'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pct_in[ph];
      stall_pct = pct_out[ph];
      random_items(8);
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;

    // Let the block settle before the verdict
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rpsa_pkg.sv
hdl/refcounted_palette_slot_allocator.sv
hdl/rpsa_checker.sv
test/testbench.sv
